// ----- src/psrl_pkg.sv -----
// shared constants and types for the per-source request limiter
package psrl_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd4;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_INSERT = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

endpackage

// ----- src/per_source_request_limiter_core.sv -----
// per-source request counter with oldest-first eviction and limit check
// a request is taken only in idle; the search state compares one slot per cycle, from
// slot 0 upward, until a match or the last filled slot; a new address then passes through
// the insert state, and the done state registers the result once the output is free
// no new request is taken until the result has been issued, so a waiting result stalls input
// reset (aresetn, synchronous): table empty, limit 4, no result pending, contents kept
module per_source_request_limiter_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [psrl_pkg::ADDR_W-1:0]           s_source_address,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [psrl_pkg::COUNT_W-1:0]          m_request_count,
    output logic                                  m_allowed,
    output logic                                  m_evicted_oldest,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [psrl_pkg::COUNT_W-1:0]          cfg_request_limit
);

    localparam int DEPTH = psrl_pkg::TABLE_DEPTH;
    localparam int IW    = psrl_pkg::IDX_W;
    localparam int UW    = psrl_pkg::USED_W;

    logic [psrl_pkg::ADDR_W-1:0]  addr_mem [DEPTH];
    logic [psrl_pkg::COUNT_W-1:0] cnt_mem  [DEPTH];

    psrl_pkg::state_t             state_reg, state_next;
    logic [UW-1:0]                used_reg, used_next;
    logic [IW-1:0]                head_reg, head_next;
    logic [IW-1:0]                idx_reg, idx_next;
    logic [psrl_pkg::ADDR_W-1:0]  key_reg, key_next;
    logic [psrl_pkg::COUNT_W-1:0] res_count_reg, res_count_next;
    logic                         res_evict_reg, res_evict_next;
    logic [psrl_pkg::COUNT_W-1:0] limit_reg;
    logic                         m_valid_reg, m_valid_next;
    logic [psrl_pkg::COUNT_W-1:0] m_count_reg, m_count_next;
    logic                         m_allowed_reg, m_allowed_next;
    logic                         m_evict_reg, m_evict_next;
    logic [psrl_pkg::ADDR_W-1:0]  rd_addr_reg;
    logic [psrl_pkg::COUNT_W-1:0] rd_cnt_reg;

    logic                         hit;
    logic                         last_slot;
    logic                         full;
    logic [IW-1:0]                ins_slot;
    logic [psrl_pkg::COUNT_W-1:0] cnt_inc;
    logic                         cnt_we, addr_we;
    logic [IW-1:0]                we_slot;
    logic [psrl_pkg::COUNT_W-1:0] cnt_wdata;
    logic                         out_free;

    assign s_ready   = (state_reg == psrl_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == psrl_pkg::ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    // the shared comparator looks at one slot per cycle
    assign hit       = (rd_addr_reg == key_reg);
    assign last_slot = ((UW'(idx_reg) + UW'(1)) == used_reg);
    assign full      = (used_reg == UW'(DEPTH));
    assign ins_slot  = full ? head_reg : used_reg[IW-1:0];
    assign cnt_inc   = (rd_cnt_reg == psrl_pkg::COUNT_MAX) ? psrl_pkg::COUNT_MAX
                                                           : rd_cnt_reg + 8'd1;

    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        head_next      = head_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        res_count_next = res_count_reg;
        res_evict_next = res_evict_reg;
        m_valid_next   = m_valid_reg;
        m_count_next   = m_count_reg;
        m_allowed_next = m_allowed_reg;
        m_evict_next   = m_evict_reg;
        cnt_we         = 1'b0;
        addr_we        = 1'b0;
        we_slot        = idx_reg;
        cnt_wdata      = cnt_inc;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            psrl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    key_next = s_source_address;
                    idx_next = '0;
                    if (used_reg == '0) begin
                        state_next = psrl_pkg::ST_INSERT;
                    end else begin
                        state_next = psrl_pkg::ST_SEARCH;
                    end
                end
            end
            psrl_pkg::ST_SEARCH: begin
                if (hit) begin
                    cnt_we         = 1'b1;
                    res_count_next = cnt_inc;
                    res_evict_next = 1'b0;
                    state_next     = psrl_pkg::ST_DONE;
                end else if (last_slot) begin
                    state_next = psrl_pkg::ST_INSERT;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            psrl_pkg::ST_INSERT: begin
                // append at the next free slot; full table: overwrite the oldest slot and move the ring head on
                cnt_we         = 1'b1;
                addr_we        = 1'b1;
                we_slot        = ins_slot;
                cnt_wdata      = 8'd1;
                res_count_next = 8'd1;
                res_evict_next = full;
                if (full) begin
                    head_next = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + IW'(1);
                end else begin
                    used_next = used_reg + UW'(1);
                end
                state_next = psrl_pkg::ST_DONE;
            end
            psrl_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_count_next   = res_count_reg;
                    m_allowed_next = (res_count_reg < limit_reg);
                    m_evict_next   = res_evict_reg;
                    state_next     = psrl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = psrl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= psrl_pkg::ST_IDLE;
            used_reg    <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
            limit_reg   <= psrl_pkg::LIMIT_RESET;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_request_limit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        key_reg       <= key_next;
        res_count_reg <= res_count_next;
        res_evict_reg <= res_evict_next;
        m_count_reg   <= m_count_next;
        m_allowed_reg <= m_allowed_next;
        m_evict_reg   <= m_evict_next;
    end

    // table storage, one slot written per cycle; the slot to compare next is read ahead
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[we_slot] <= cnt_wdata;
        end
        if (addr_we) begin
            addr_mem[we_slot] <= key_reg;
        end
        rd_addr_reg <= addr_mem[idx_next];
        rd_cnt_reg  <= cnt_mem[idx_next];
    end

    assign m_valid          = m_valid_reg;
    assign m_request_count  = m_count_reg;
    assign m_allowed        = m_allowed_reg;
    assign m_evicted_oldest = m_evict_reg;

`ifndef SYNTHESIS
    a_evict_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted_oldest |-> used_reg == UW'(DEPTH))
        else $error("eviction reported with table not full");

    a_head_moves_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg != '0 |-> used_reg == UW'(DEPTH))
        else $error("ring head advanced before table filled");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_request_count != '0)
        else $error("result transfer with zero count");

    a_search_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == psrl_pkg::ST_SEARCH |-> UW'(idx_reg) < used_reg)
        else $error("search index beyond filled slots");
`endif

endmodule

// ----- tb/request_count_checker.sv -----
// checker that predicts each limiter result and compares it with the result channel
module request_count_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [psrl_pkg::ADDR_W-1:0]  s_source_address,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [psrl_pkg::COUNT_W-1:0] m_request_count,
    input  logic                         m_allowed,
    input  logic                         m_evicted_oldest,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [psrl_pkg::COUNT_W-1:0] cfg_request_limit,
    output int                           fail_count,
    output int                           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [psrl_pkg::COUNT_W-1:0] count;
        logic                         allowed;
        logic                         evicted;
    } tally_t;

    logic [psrl_pkg::ADDR_W-1:0]  known_addr  [psrl_pkg::TABLE_DEPTH];
    logic [psrl_pkg::COUNT_W-1:0] known_count [psrl_pkg::TABLE_DEPTH];
    int                           live_entries;
    logic [psrl_pkg::COUNT_W-1:0] limit_now;
    tally_t                       expected_tallies [$];
    int                           mismatches;

    // raises or appends the entry for one source and returns what the block should report
    function automatic tally_t tally_request(input logic [psrl_pkg::ADDR_W-1:0] addr);
        tally_t t;
        int     slot;
        slot = -1;
        for (int k = 0; k < live_entries; k++) begin
            if (slot < 0 && known_addr[k] == addr)
                slot = k;
        end
        t.evicted = 1'b0;
        if (slot >= 0) begin
            if (known_count[slot] != psrl_pkg::COUNT_MAX)
                known_count[slot] = known_count[slot] + 1'b1;
            t.count = known_count[slot];
        end else begin
            // full table: oldest arrival goes, the rest move down one slot
            if (live_entries == psrl_pkg::TABLE_DEPTH) begin
                for (int k = 0; k < psrl_pkg::TABLE_DEPTH - 1; k++) begin
                    known_addr[k]  = known_addr[k+1];
                    known_count[k] = known_count[k+1];
                end
                live_entries--;
                t.evicted = 1'b1;
            end
            known_addr[live_entries]  = addr;
            known_count[live_entries] = 8'd1;
            live_entries++;
            t.count = 8'd1;
        end
        t.allowed = (t.count < limit_now);
        return t;
    endfunction

    task automatic log_mismatch(input string why, input tally_t want, input tally_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s: expected count %0d allowed %0b evicted %0b",
                     $time, why, want.count, want.allowed, want.evicted);
            $display("    got count %0d allowed %0b evicted %0b",
                     got.count, got.allowed, got.evicted);
        end
    endtask

    always @(posedge aclk) begin : watch
        tally_t want;
        tally_t got;
        if (!aresetn) begin
            live_entries = 0;
            limit_now    = psrl_pkg::LIMIT_RESET;
            mismatches   = 0;
            expected_tallies.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                limit_now = cfg_request_limit;
            if (s_valid && s_ready)
                expected_tallies.push_back(tally_request(s_source_address));
            if (m_valid && m_ready) begin
                got = '{m_request_count, m_allowed, m_evicted_oldest};
                if (expected_tallies.size() == 0) begin
                    log_mismatch("result with nothing pending", '0, got);
                end else begin
                    want = expected_tallies.pop_front();
                    if (want != got)
                        log_mismatch("result mismatch", want, got);
                end
            end
            fail_count  <= mismatches;
            outstanding <= expected_tallies.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// testbench top for the request limiter: stimulus, result pacing, watchdog and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic                         aclk              = 1'b0;
    logic                         aresetn           = 1'b0;
    logic                         s_valid           = 1'b0;
    logic                         s_ready;
    logic [psrl_pkg::ADDR_W-1:0]  s_source_address  = '0;
    logic                         m_valid;
    logic                         m_ready           = 1'b0;
    logic [psrl_pkg::COUNT_W-1:0] m_request_count;
    logic                         m_allowed;
    logic                         m_evicted_oldest;
    logic                         cfg_valid         = 1'b0;
    logic                         cfg_ready;
    logic [psrl_pkg::COUNT_W-1:0] cfg_request_limit = '0;

    int                           fail_count;
    int                           outstanding;
    int                           quiet_cycles      = 0;
    int                           rx_hold           = 0;
    bit                           tx_quiet          = 1'b0;
    bit                           rx_quiet          = 1'b0;
    logic [psrl_pkg::ADDR_W-1:0]  pool [24];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    per_source_request_limiter_core u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_source_address  (s_source_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_request_count   (m_request_count),
        .m_allowed         (m_allowed),
        .m_evicted_oldest  (m_evicted_oldest),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_request_limit (cfg_request_limit)
    );

    request_count_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_source_address  (s_source_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_request_count   (m_request_count),
        .m_allowed         (m_allowed),
        .m_evicted_oldest  (m_evicted_oldest),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_request_limit (cfg_request_limit),
        .fail_count        (fail_count),
        .outstanding       (outstanding)
    );

    // result side: after each transfer hold ready low for a drawn number of cycles
    always @(posedge aclk) begin : rx_pace
        int stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (m_valid && m_ready) begin
            if ($urandom_range(0, 39) == 0)
                rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 5);
            rx_hold <= stall;
            m_ready <= (stall == 0);
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= (rx_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic [psrl_pkg::ADDR_W-1:0] addr);
        int gap;
        if ($urandom_range(0, 29) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_source_address <= addr;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and wait until every pending result has been taken
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic set_limit(input logic [psrl_pkg::COUNT_W-1:0] value);
        cfg_valid         <= 1'b1;
        cfg_request_limit <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // addresses one bit away from a base, mixed with unrelated ones
    task automatic build_pool(input int size);
        logic [psrl_pkg::ADDR_W-1:0] base;
        base    = $urandom;
        pool[0] = base;
        for (int k = 1; k < size; k++)
            pool[k] = (k % 2) ? base ^ (32'h1 << $urandom_range(0, 31)) : $urandom;
    endtask

    initial begin
        logic [psrl_pkg::ADDR_W-1:0] hot;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limit: count crosses it, then fill, evict and hit at full table
        repeat (5) send_request('0);
        send_request('1);
        for (int k = 0; k < 15; k++)
            send_request(32'h1 << k);
        send_request('1);
        send_request('0);
        drain_results();

        // highest limit, one address hammered until its count saturates
        set_limit(psrl_pkg::COUNT_MAX);
        build_pool(6);
        hot = $urandom;
        for (int i = 0; i < 320; i++)
            send_request(($urandom_range(0, 9) != 0) ? hot : pool[$urandom_range(0, 5)]);
        drain_results();

        // zero limit: nothing is ever allowed
        set_limit(8'd0);
        build_pool(24);
        for (int i = 0; i < 100; i++)
            send_request(pool[$urandom_range(0, 23)]);
        drain_results();

        // limit of one with fresh addresses, nearly every transfer evicts
        set_limit(8'd1);
        for (int i = 0; i < 80; i++)
            send_request($urandom);
        drain_results();

        set_limit(psrl_pkg::COUNT_W'($urandom_range(2, 254)));
        build_pool(17);
        for (int i = 0; i < 150; i++) begin
            if (i == 75)
                drain_results();
            send_request(pool[$urandom_range(0, 16)]);
        end
        drain_results();

        repeat (psrl_pkg::TABLE_DEPTH + 8) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
